@@ hw/rtl/url_percent_decoder_unit_defines.svh @@
// ============================================================================
// URL percent decoder assertion macros
// Concurrent assertion forms used by the decoder's queue module.
// ============================================================================
`ifndef URL_PERCENT_DECODER_UNIT_DEFINES_SVH
`define URL_PERCENT_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UPD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("upd: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define UPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("upd: next-cycle check failed");

`endif

@@ hw/rtl/upd_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// URL percent decoder package
// Character constants, the hex digit decoder and the types shared by modules.
// ============================================================================
package upd_pkg;

    localparam logic [7:0] PCT_CHAR = 8'h25;
    localparam logic [7:0] CHAR_0   = 8'h30;
    localparam logic [7:0] CHAR_9   = 8'h39;
    localparam logic [7:0] CHAR_LA  = 8'h61;
    localparam logic [7:0] CHAR_LF  = 8'h66;
    localparam logic [7:0] CHAR_UA  = 8'h41;
    localparam logic [7:0] CHAR_UF  = 8'h46;
    localparam logic [7:0] TEN      = 8'd10;
    localparam logic [4:0] NOT_HEX  = 5'd16;

    // Most bytes one input can cause.
    localparam int unsigned MAX_RESULTS = 3;

    // The bytes one input causes, in emission order.
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [1:0]                  cnt;
        logic                        fin;
    } t_op;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    // Value of a hex digit character, or NOT_HEX for any other byte.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = NOT_HEX;
        if (c >= CHAR_0 && c <= CHAR_9) begin
            v = 5'(c - CHAR_0);
        end else if (c >= CHAR_LA && c <= CHAR_LF) begin
            v = 5'(c - CHAR_LA + TEN);
        end else if (c >= CHAR_UA && c <= CHAR_UF) begin
            v = 5'(c - CHAR_UA + TEN);
        end
        return v;
    endfunction

endpackage

@@ hw/rtl/upd_channels.sv @@
`timescale 1ns / 1ps
// ============================================================================
// URL percent decoder channels
// Valid/ready interfaces for the raw byte input and the decoded byte output.
// ============================================================================
interface upd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_final;

    modport source (output valid, output in_byte, output in_final, input ready);
    modport sink   (input valid, input in_byte, input in_final, output ready);
endinterface

interface upd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       component_end;

    modport source (output valid, output out_byte, output run_last,
                    output component_end, input ready);
    modport sink   (input valid, input out_byte, input run_last,
                    input component_end, output ready);
endinterface

@@ hw/rtl/url_percent_decoder_unit.sv @@
`timescale 1ns / 1ps
// ============================================================================
// URL percent decoder unit
// Decodes percent escapes in a URL component streamed one byte at a time.
// ============================================================================
// Usage:
//   i_in carries one raw character per transaction, with in_final set on the
//   last character of a component. o_out carries the decoded characters; each
//   input causes zero to three output transactions, run_last marks the last
//   one caused by an input, and component_end marks the last character of the
//   component. A valid "%XY" escape (hex digits of either case) becomes one
//   byte; a broken escape passes its '%' and any held digit through as text.
//   The first output caused by an input passes through the queue and then the
//   output register before it is presented on o_out.
//   Throughput: one input per cycle while o_out.ready is high and each input
//   yields at most one output. The output register emits one byte per cycle,
//   so an input that yields two or three bytes holds it for each byte in turn;
//   the QUEUE_DEPTH-entry queue between front and back end absorbs these bursts.
//   Stalls: when o_out.ready is low the output register holds, the queue fills,
//   and i_in.ready drops only once all QUEUE_DEPTH entries are occupied.
//   Reset (i_rst_n low, synchronous) clears the escape state, empties the queue
//   and drops o_out.valid; i_in.ready is high right after reset.
// ============================================================================
module url_percent_decoder_unit #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    upd_in_if.sink    i_in,
    upd_out_if.source o_out
);

    // Per-input byte group handed from the front end to the queue.
    upd_pkg::t_op     w_push_op;
    upd_pkg::t_op     w_head;
    upd_pkg::t_q_stat w_stat;
    logic             w_push;
    logic             w_pop;

    // Front end: owns the escape state and classifies every accepted byte.
    // Inputs that only extend an escape push nothing into the queue.
    upd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_stat  (w_stat),
        .o_push  (w_push),
        .o_op    (w_push_op)
    );

    // Queue decouples input acceptance from output backpressure.
    upd_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_push_op),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_stat)
    );

    // Back end: sends the head group out one byte per output transaction and
    // pops it as its last byte enters the output register.
    upd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_stat  (w_stat),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

@@ hw/rtl/upd_front.sv @@
`timescale 1ns / 1ps
// ============================================================================
// URL percent decoder front end
// Accepts raw bytes, tracks the escape state and forms the output bytes.
// ============================================================================
module upd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    upd_in_if.sink          i_in,
    input  upd_pkg::t_q_stat i_stat,
    output logic            o_push,
    output upd_pkg::t_op    o_op
);

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_PCT   = 3'b010,
        PH_DIGIT = 3'b100
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_held, n_held;
    logic        w_accept;
    logic [4:0]  w_hv_b, w_hv_held;
    logic        w_b_hex, w_b_pct;
    logic [upd_pkg::MAX_RESULTS-1:0][7:0] v_bytes;
    logic [1:0]  v_cnt;
    logic [7:0]  b;

    assign b         = i_in.in_byte;
    assign i_in.ready = !i_stat.full;
    assign w_accept  = i_in.valid && i_in.ready;
    assign w_hv_b    = upd_pkg::hex_value(b);
    assign w_hv_held = upd_pkg::hex_value(r_held);
    assign w_b_hex   = (w_hv_b != upd_pkg::NOT_HEX);
    assign w_b_pct   = (b == upd_pkg::PCT_CHAR);

    always_comb begin
        v_bytes = '0;
        v_cnt   = '0;
        n_phase = r_phase;
        n_held  = r_held;
        unique case (r_phase)
            PH_PCT: begin
                if (w_b_hex) begin
                    n_held  = b;
                    n_phase = PH_DIGIT;
                end else begin
                    v_bytes[v_cnt] = upd_pkg::PCT_CHAR;
                    v_cnt = v_cnt + 2'd1;
                    if (w_b_pct) begin
                        n_phase = PH_PCT;
                    end else begin
                        v_bytes[v_cnt] = b;
                        v_cnt   = v_cnt + 2'd1;
                        n_phase = PH_IDLE;
                    end
                end
            end
            PH_DIGIT: begin
                if (w_b_hex) begin
                    v_bytes[v_cnt] = {w_hv_held[3:0], w_hv_b[3:0]};
                    v_cnt   = v_cnt + 2'd1;
                    n_phase = PH_IDLE;
                end else begin
                    v_bytes[v_cnt] = upd_pkg::PCT_CHAR;
                    v_cnt = v_cnt + 2'd1;
                    v_bytes[v_cnt] = r_held;
                    v_cnt = v_cnt + 2'd1;
                    if (w_b_pct) begin
                        n_phase = PH_PCT;
                    end else begin
                        v_bytes[v_cnt] = b;
                        v_cnt   = v_cnt + 2'd1;
                        n_phase = PH_IDLE;
                    end
                end
            end
            default: begin
                // Idle, and any illegal code, scan the byte afresh.
                if (w_b_pct) begin
                    n_phase = PH_PCT;
                end else begin
                    v_bytes[v_cnt] = b;
                    v_cnt   = v_cnt + 2'd1;
                    n_phase = PH_IDLE;
                end
            end
        endcase

        // On the final byte, any held characters are flushed as plain text.
        if (i_in.in_final) begin
            if (n_phase == PH_PCT) begin
                v_bytes[v_cnt] = upd_pkg::PCT_CHAR;
                v_cnt = v_cnt + 2'd1;
            end else if (n_phase == PH_DIGIT) begin
                v_bytes[v_cnt] = upd_pkg::PCT_CHAR;
                v_cnt = v_cnt + 2'd1;
                v_bytes[v_cnt] = n_held;
                v_cnt = v_cnt + 2'd1;
            end
            n_phase = PH_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_held  <= '0;
        end else if (w_accept) begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

    assign o_push    = w_accept && (v_cnt != 2'd0);
    assign o_op.bytes = v_bytes;
    assign o_op.cnt   = v_cnt;
    assign o_op.fin   = i_in.in_final;

endmodule

@@ hw/rtl/upd_queue.sv @@
`timescale 1ns / 1ps
// ============================================================================
// URL percent decoder queue
// Short FIFO of per-input byte groups between the front and back ends.
// ============================================================================
`include "url_percent_decoder_unit_defines.svh"

module upd_queue #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  upd_pkg::t_op     i_op,
    input  logic             i_pop,
    output upd_pkg::t_op     o_head,
    output upd_pkg::t_q_stat o_stat
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    upd_pkg::t_op     r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_full, w_empty;

    assign w_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_empty = (r_count == '0);
    assign o_stat.full  = w_full;
    assign o_stat.empty = w_empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    `UPD_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, i_push, !w_full)
    `UPD_ASSERT_IMPL(a_no_underflow, i_clk, i_rst_n, i_pop, !w_empty)
    `UPD_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(QUEUE_DEPTH))
    `UPD_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + CNT_W'(1))

endmodule

@@ hw/rtl/upd_back.sv @@
`timescale 1ns / 1ps
// ============================================================================
// URL percent decoder back end
// Walks the bytes of the queue head into the registered output channel.
// ============================================================================
module upd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  upd_pkg::t_op     i_head,
    input  upd_pkg::t_q_stat i_stat,
    output logic             o_pop,
    upd_out_if.source        o_out
);

    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       r_end;
    logic       w_load, w_take, w_last;

    assign w_load = !r_valid || o_out.ready;
    assign w_take = w_load && !i_stat.empty;
    assign w_last = (r_idx == (i_head.cnt - 2'd1));
    assign o_pop  = w_take && w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (w_load) begin
                r_valid <= !i_stat.empty;
            end
            if (w_take) begin
                r_idx <= w_last ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_byte <= i_head.bytes[r_idx];
            r_last <= w_last;
            r_end  <= w_last && i_head.fin;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.out_byte      = r_byte;
    assign o_out.run_last      = r_last;
    assign o_out.component_end = r_end;

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// URL percent decoder unit testbench
// Streams URL components into the decoder, first from a short directed table
// and then as random well-formed and broken escape sequences, and checks
// each output against the table or a cycle-free escape state machine model.
// ============================================================================
module tb;

    // Minimum number of random raw characters fed after the directed table.
    localparam int RANDOM_CHARS = 410;
    // Percentage of cycles in which either side holds off.
    localparam int IDLE_PCT = 37;
    // Watchdog limit, far above the slowest correct run.
    localparam int CYCLE_LIMIT = 100000;
    // Quiet cycles after the last expected character, for stray outputs.
    localparam int DRAIN_CYCLES = 12;

    // Escape progress of the model, mirroring the decoder's own phases.
    typedef enum logic [1:0] {
        ESC_NONE  = 2'd0,
        ESC_PCT   = 2'd1,
        ESC_DIGIT = 2'd2
    } t_esc_phase;

    // One decoded character as it should appear on the output channel.
    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       component_end;
    } t_decoded;

    typedef logic [7:0] t_byte_q[$];

    // A row of the directed table. Where hand_typed is set, the expected
    // characters are written out in exp_bytes; otherwise the model decides.
    typedef struct packed {
        logic [7:0]      ch;
        logic            fin;
        logic            hand_typed;
        logic [1:0]      exp_count;
        logic [0:2][7:0] exp_bytes;
    } t_step_row;

    localparam int DIRECTED_ROWS = 26;

    logic i_clk;
    logic i_rst_n;

    upd_in_if  in_ch ();
    upd_out_if out_ch ();

    url_percent_decoder_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // The directed walk covers plain characters at both ends of the byte
    // range, escapes with lower- and upper-case digits, "%00", an escape that
    // decodes to '%' (which must not open a new escape), broken escapes at the
    // second and third character, a '%' that restarts an escape, and every
    // way a component can end with an escape still open.
    t_step_row escape_table [DIRECTED_ROWS] = '{
        '{"a",    1'b0, 1'b1, 2'd1, '{"a",   8'h00, 8'h00}},
        '{8'h00,  1'b0, 1'b1, 2'd1, '{8'h00, 8'h00, 8'h00}},
        '{8'hFF,  1'b1, 1'b1, 2'd1, '{8'hFF, 8'h00, 8'h00}},
        '{"%",    1'b0, 1'b1, 2'd0, '{8'h00, 8'h00, 8'h00}},
        '{"4",    1'b0, 1'b1, 2'd0, '{8'h00, 8'h00, 8'h00}},
        '{"1",    1'b0, 1'b1, 2'd1, '{8'h41, 8'h00, 8'h00}},
        '{"%",    1'b0, 1'b0, 2'd0, '{8'h00, 8'h00, 8'h00}},
        '{"f",    1'b0, 1'b0, 2'd0, '{8'h00, 8'h00, 8'h00}},
        '{"F",    1'b0, 1'b1, 2'd1, '{8'hFF, 8'h00, 8'h00}},
        '{"%",    1'b0, 1'b0, 2'd0, '{8'h00, 8'h00, 8'h00}},
        '{"0",    1'b0, 1'b0, 2'd0, '{8'h00, 8'h00, 8'h00}},
        '{"0",    1'b0, 1'b1, 2'd1, '{8'h00, 8'h00, 8'h00}},
        '{"%",    1'b0, 1'b0, 2'd0, '{8'h00, 8'h00, 8'h00}},
        '{"2",    1'b0, 1'b0, 2'd0, '{8'h00, 8'h00, 8'h00}},
        '{"5",    1'b0, 1'b1, 2'd1, '{"%",   8'h00, 8'h00}},
        '{"%",    1'b0, 1'b0, 2'd0, '{8'h00, 8'h00, 8'h00}},
        '{"g",    1'b0, 1'b1, 2'd2, '{"%",   "g",   8'h00}},
        '{"%",    1'b0, 1'b0, 2'd0, '{8'h00, 8'h00, 8'h00}},
        '{"%",    1'b0, 1'b1, 2'd1, '{"%",   8'h00, 8'h00}},
        '{"A",    1'b0, 1'b0, 2'd0, '{8'h00, 8'h00, 8'h00}},
        '{"z",    1'b0, 1'b0, 2'd0, '{8'h00, 8'h00, 8'h00}},
        '{"%",    1'b0, 1'b0, 2'd0, '{8'h00, 8'h00, 8'h00}},
        '{"9",    1'b1, 1'b1, 2'd2, '{"%",   "9",   8'h00}},
        '{"%",    1'b1, 1'b1, 2'd1, '{"%",   8'h00, 8'h00}},
        '{"%",    1'b0, 1'b0, 2'd0, '{8'h00, 8'h00, 8'h00}},
        '{"%",    1'b1, 1'b1, 2'd2, '{"%",   "%",   8'h00}}
    };

    // Model state and bookkeeping.
    t_esc_phase esc_phase;
    logic [7:0] esc_digit;
    t_decoded   decoded_q[$];
    int         error_count;
    int         chars_fed;
    int         components_fed;
    int         chars_checked;
    int         escapes_decoded;
    int         cycle_count;
    // While set, neither side idles, so the decoder runs at full rate.
    logic       steady;

    // 10 ns clock. It starts low so that the first rising edge comes after
    // the initial values are in place.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** url_percent_decoder_unit: FAILED **");
            $finish;
        end
    end

    // Gives the value of a hex digit character in v and returns 1; returns 0, with v zero, for any other byte.
    function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
        v = 4'd0;
        if (c >= "0" && c <= "9") begin
            v = 4'(c - "0");
            return 1'b1;
        end
        if (c >= "a" && c <= "f") begin
            v = 4'(c - "a" + 8'd10);
            return 1'b1;
        end
        if (c >= "A" && c <= "F") begin
            v = 4'(c - "A" + 8'd10);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Advances the model by one raw character and returns the characters it
    // releases, in order.
    function automatic void decode_step(input logic [7:0] ch, input logic fin,
                                        output t_byte_q released);
        logic [3:0] hi;
        logic [3:0] lo;
        logic       rescan;
        released = {};
        rescan   = 1'b1;
        case (esc_phase)
            ESC_PCT: begin
                if (hex_nibble(ch, lo)) begin
                    esc_digit = ch;
                    esc_phase = ESC_DIGIT;
                    rescan    = 1'b0;
                end else begin
                    released.push_back(upd_pkg::PCT_CHAR);
                    esc_phase = ESC_NONE;
                end
            end
            ESC_DIGIT: begin
                if (hex_nibble(ch, lo)) begin
                    void'(hex_nibble(esc_digit, hi));
                    released.push_back({hi, lo});
                    escapes_decoded++;
                    esc_phase = ESC_NONE;
                    rescan    = 1'b0;
                end else begin
                    // The broken escape goes out as text, then the character
                    // is scanned afresh.
                    released.push_back(upd_pkg::PCT_CHAR);
                    released.push_back(esc_digit);
                    esc_phase = ESC_NONE;
                end
            end
            default: esc_phase = ESC_NONE;
        endcase
        if (rescan) begin
            if (ch == upd_pkg::PCT_CHAR) begin
                esc_phase = ESC_PCT;
            end else begin
                released.push_back(ch);
            end
        end
        // The end of a component flushes whatever escape is still open.
        if (fin) begin
            if (esc_phase == ESC_PCT) begin
                released.push_back(upd_pkg::PCT_CHAR);
            end else if (esc_phase == ESC_DIGIT) begin
                released.push_back(upd_pkg::PCT_CHAR);
                released.push_back(esc_digit);
            end
            esc_phase = ESC_NONE;
        end
    endfunction

    // Queues the characters one input releases, marking the last of them.
    task automatic expect_chars(input t_byte_q released, input logic fin);
        t_decoded d;
        foreach (released[k]) begin
            d.data          = released[k];
            d.run_last      = (k == released.size() - 1);
            d.component_end = d.run_last && fin;
            decoded_q.push_back(d);
        end
    endtask

    // Presents one raw character and returns at the edge that accepts it.
    // Idle cycles before it drop valid; a back-to-back transaction keeps valid
    // high through the accepting edge.
    task automatic feed_char(input logic [7:0] ch, input logic fin);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.in_byte  <= ch;
        in_ch.in_final <= fin;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
        chars_fed++;
        if (fin) begin
            components_fed++;
        end
    endtask

    // Output side: ready follows its own random idling, and every accepted
    // transaction is checked against the oldest expected character. Values
    // are read at the edge itself, before any update of this time step.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                check_output();
            end
            out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic check_output();
        t_decoded want;
        if (decoded_q.size() == 0) begin
            $error("unexpected output character 0x%02h", out_ch.out_byte);
            error_count++;
        end else begin
            want = decoded_q.pop_front();
            chars_checked++;
            if (out_ch.out_byte !== want.data) begin
                $error("out_byte: expected 0x%02h, got 0x%02h", want.data, out_ch.out_byte);
                error_count++;
            end
            if (out_ch.run_last !== want.run_last) begin
                $error("run_last: expected %0b, got %0b", want.run_last, out_ch.run_last);
                error_count++;
            end
            if (out_ch.component_end !== want.component_end) begin
                $error("component_end: expected %0b, got %0b",
                       want.component_end, out_ch.component_end);
                error_count++;
            end
        end
    endtask

    // Picks a hex digit character of either case.
    function automatic logic [7:0] any_hex_char();
        string digits;
        digits = "0123456789abcdefABCDEF";
        return digits[$urandom_range(21)];
    endfunction

    // Picks any byte that is not a hex digit ('%' included).
    function automatic logic [7:0] any_non_hex();
        logic [7:0] c;
        logic [3:0] v;
        do begin
            c = 8'($urandom_range(255));
        end while (hex_nibble(c, v));
        return c;
    endfunction

    // Stimulus.
    initial begin
        t_byte_q released;
        t_byte_q typed;
        t_byte_q component;
        int      random_fed;
        int      pieces;
        int      pick;

        in_ch.valid     = 1'b0;
        in_ch.in_byte   = 8'h00;
        in_ch.in_final  = 1'b0;
        out_ch.ready    = 1'b0;
        i_rst_n         = 1'b0;
        steady          = 1'b0;
        esc_phase       = ESC_NONE;
        esc_digit       = 8'h00;
        error_count     = 0;
        chars_fed       = 0;
        components_fed  = 0;
        chars_checked   = 0;
        escapes_decoded = 0;
        cycle_count     = 0;
        random_fed      = 0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table. The model runs on every row to keep its state in
        // step; hand-typed rows take their expectation from the table.
        foreach (escape_table[r]) begin
            feed_char(escape_table[r].ch, escape_table[r].fin);
            decode_step(escape_table[r].ch, escape_table[r].fin, released);
            if (escape_table[r].hand_typed) begin
                typed = {};
                for (int k = 0; k < int'(escape_table[r].exp_count); k++) begin
                    typed.push_back(escape_table[r].exp_bytes[k]);
                end
                expect_chars(typed, escape_table[r].fin);
            end else begin
                expect_chars(released, escape_table[r].fin);
            end
        end

        // Random components. Most pieces are plain text or valid escapes, so
        // the decoder spends most of its time deep in escape handling; the
        // rest are broken or truncated escapes, and a component that ends on a
        // truncated escape ends with that escape still open.
        while (random_fed < RANDOM_CHARS) begin
            component = {};
            pieces = $urandom_range(12, 1);
            repeat (pieces) begin
                pick = $urandom_range(99);
                if (pick < 40) begin
                    component.push_back(8'($urandom_range(255)));
                end else if (pick < 70) begin
                    component.push_back(upd_pkg::PCT_CHAR);
                    component.push_back(any_hex_char());
                    component.push_back(any_hex_char());
                end else if (pick < 80) begin
                    component.push_back(upd_pkg::PCT_CHAR);
                    component.push_back(any_non_hex());
                end else if (pick < 90) begin
                    component.push_back(upd_pkg::PCT_CHAR);
                    component.push_back(any_hex_char());
                    component.push_back(any_non_hex());
                end else if (pick < 95) begin
                    component.push_back(upd_pkg::PCT_CHAR);
                end else begin
                    component.push_back(upd_pkg::PCT_CHAR);
                    component.push_back(any_hex_char());
                end
            end
            foreach (component[k]) begin
                // A stretch in the middle runs with neither side idling.
                steady = (random_fed >= 150 && random_fed < 250);
                feed_char(component[k], k == component.size() - 1);
                decode_step(component[k], k == component.size() - 1, released);
                expect_chars(released, k == component.size() - 1);
                random_fed++;
            end
        end
        in_ch.valid <= 1'b0;
        steady = 1'b0;

        while (decoded_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Fed %0d raw characters in %0d components, %0d escapes decoded.",
                 chars_fed, components_fed, escapes_decoded);
        $display("Checked %0d output characters, %0d mismatches.",
                 chars_checked, error_count);
        if (error_count == 0) begin
            $display("** url_percent_decoder_unit: PASSED **");
        end else begin
            $display("** url_percent_decoder_unit: FAILED **");
        end
        $finish;
    end

endmodule
